// ===== src/dopi_pkg.sv =====
// dopi_pkg: shared constants, pipeline context types and saturation helper
// for the dense-output interpolator. No dependencies.
package dopi_pkg;

  localparam int unsigned COMPONENTS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned COMP_W         = 4;
  localparam int unsigned N_COEF         = 5;
  // divider retires this many quotient bits per stage
  localparam int unsigned DIV_BITS       = 4;
  localparam int unsigned DIV_STEPS      = DATA_W / DIV_BITS;
  // load stage + digit stages + sign/saturate stage
  localparam int unsigned DIV_LAT        = DIV_STEPS + 2;
  localparam int unsigned N_HORNER       = 4;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct packed {
    logic                                fault;
    logic [COMP_W-1:0]                   comp;
    logic [N_COEF-1:0][DATA_W-1:0]       coef;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [31:0] theta;
    logic signed [31:0] theta1;
  } hctx_t;

  function automatic logic [31:0] sat_s32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/dopi_ram.sv =====
// dopi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dopi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dopi_div.sv =====
// dopi_div: pipelined restoring divider, DIV_BITS quotient bits per stage,
// signed result truncated toward zero and saturated. Depends on dopi_pkg.
module dopi_div #(
  parameter int unsigned FRAC_BITS = dopi_pkg::FRAC_BITS_DEF,
  localparam int unsigned NW       = 33 + FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  dopi_pkg::ctx_t      ctx_i,
  input  logic [NW-1:0]       num_i,
  input  logic [31:0]         den_i,
  input  logic                neg_i,
  output logic                valid_o,
  output dopi_pkg::ctx_t      ctx_o,
  output logic signed [31:0]  quot_o
);

  localparam int unsigned S = dopi_pkg::DIV_STEPS;

  logic           valid_q [S+1];
  dopi_pkg::ctx_t ctx_q   [S+1];
  logic [31:0]    rem_q   [S+1];
  logic [31:0]    lo_q    [S+1];
  logic [31:0]    quo_q   [S+1];
  logic [31:0]    den_q   [S+1];
  logic           neg_q   [S+1];
  logic           ovf_q   [S+1];

  logic [31:0]    rem_d   [S];
  logic [31:0]    lo_d    [S];
  logic [31:0]    quo_d   [S];

  logic           out_valid_q;
  dopi_pkg::ctx_t out_ctx_q;
  logic [31:0]    out_quot_q;
  logic [31:0]    quot_d;

  // digit steps: shift one numerator bit into the remainder, trial subtract
  always_comb begin
    logic [31:0] r;
    logic [31:0] l;
    logic [31:0] q;
    logic [32:0] t;
    for (int s = 0; s < S; s++) begin
      r = rem_q[s];
      l = lo_q[s];
      q = quo_q[s];
      for (int b = 0; b < dopi_pkg::DIV_BITS; b++) begin
        t = {r, l[31]};
        l = {l[30:0], 1'b0};
        if (t >= {1'b0, den_q[s]}) begin
          t = t - {1'b0, den_q[s]};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
        r = t[31:0];
      end
      rem_d[s] = r;
      lo_d[s]  = l;
      quo_d[s] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= S; s++) begin
        valid_q[s] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int s = 0; s < S; s++) begin
        valid_q[s+1] <= valid_q[s];
      end
      out_valid_q <= valid_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q[0] <= ctx_i;
    rem_q[0] <= 32'(num_i[NW-1:32]);
    lo_q[0]  <= num_i[31:0];
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    neg_q[0] <= neg_i;
    // quotient needs more than 32 bits
    ovf_q[0] <= 33'(num_i[NW-1:32]) >= {1'b0, den_i};
    for (int s = 0; s < S; s++) begin
      ctx_q[s+1] <= ctx_q[s];
      rem_q[s+1] <= rem_d[s];
      lo_q[s+1]  <= lo_d[s];
      quo_q[s+1] <= quo_d[s];
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      ovf_q[s+1] <= ovf_q[s];
    end
    out_ctx_q  <= ctx_q[S];
    out_quot_q <= quot_d;
  end

  always_comb begin
    if (neg_q[S]) begin
      if (ovf_q[S] || (quo_q[S] > 32'h8000_0000)) begin
        quot_d = 32'h8000_0000;
      end else begin
        quot_d = -quo_q[S];
      end
    end else begin
      if (ovf_q[S] || quo_q[S][31]) begin
        quot_d = 32'h7fff_ffff;
      end else begin
        quot_d = quo_q[S];
      end
    end
  end

  assign valid_o = out_valid_q;
  assign ctx_o   = out_ctx_q;
  assign quot_o  = $signed(out_quot_q);

endmodule

// ===== src/dopi_horner.sv =====
// dopi_horner: one Horner step, multiply stage then floor-shift, add and
// saturate stage. Depends on dopi_pkg.
module dopi_horner #(
  parameter int unsigned FRAC_BITS = dopi_pkg::FRAC_BITS_DEF,
  parameter int unsigned COEF_IDX  = 0,
  parameter bit          USE_T1    = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dopi_pkg::hctx_t    ctx_i,
  input  logic signed [31:0] acc_i,
  output logic               valid_o,
  output dopi_pkg::hctx_t    ctx_o,
  output logic signed [31:0] acc_o
);

  logic signed [31:0] factor;
  logic signed [63:0] prod_d, prod_q, shifted;
  logic               mul_valid_q, add_valid_q;
  dopi_pkg::hctx_t    mul_ctx_q, add_ctx_q;
  logic [31:0]        acc_d, acc_q;

  assign factor  = USE_T1 ? ctx_i.theta1 : ctx_i.theta;
  assign prod_d  = 64'(factor) * 64'(acc_i);
  // arithmetic shift rounds toward minus infinity
  assign shifted = prod_q >>> FRAC_BITS;
  assign acc_d   = dopi_pkg::sat_s32(66'(shifted) +
                   66'($signed(mul_ctx_q.ctx.coef[COEF_IDX])));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      add_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= valid_i;
      add_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    mul_ctx_q <= ctx_i;
    acc_q     <= acc_d;
    add_ctx_q <= mul_ctx_q;
  end

  assign valid_o = add_valid_q;
  assign ctx_o   = add_ctx_q;
  assign acc_o   = $signed(acc_q);

endmodule

// ===== src/dense_output_interpolator.sv =====
// dense_output_interpolator: top level, coefficient RAM, step record,
// theta divider and four Horner steps. Depends on dopi_pkg, dopi_ram,
// dopi_div, dopi_horner.
//
//   channel  | handshake        | fields
//   ---------+------------------+--------------------------------------------
//   input    | start, busy      | action_i, component_i, coef_*_i,
//            |                  | start_time_i, step_width_i, query_time_i
//   result   | done_o strobe    | component_out_o, interp_value_o, fault_o
//
// One beat per cycle in, busy is never raised. A query's result passes
// through 2 operand stages, 10 divider stages (8 digit stages of 4
// quotient bits each set the depth), 1 stage for 1-theta, and 2 stages
// per Horner step. Loads write the RAM and the record registers and give
// no result. Reset clears the record and the valid bits; the RAM is not
// cleared. Results cannot be stalled.
module dense_output_interpolator #(
  parameter int unsigned COMPONENTS = dopi_pkg::COMPONENTS_DEF,
  parameter int unsigned FRAC_BITS  = dopi_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [3:0]  component_i,
  input  logic [31:0] coef_value_i,
  input  logic [31:0] coef_diff_i,
  input  logic [31:0] coef_second_i,
  input  logic [31:0] coef_third_i,
  input  logic [31:0] coef_fourth_i,
  input  logic [31:0] start_time_i,
  input  logic [31:0] step_width_i,
  input  logic [31:0] query_time_i,
  output logic        done_o,
  output logic [3:0]  component_out_o,
  output logic [31:0] interp_value_o,
  output logic        fault_o
);

  localparam int unsigned AW   = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int unsigned CW   = (AW > dopi_pkg::COMP_W) ? AW : dopi_pkg::COMP_W;
  localparam int unsigned NW   = 33 + FRAC_BITS;
  localparam int unsigned RAMW = dopi_pkg::N_COEF * dopi_pkg::DATA_W;
  localparam int unsigned LAT  = 2 + dopi_pkg::DIV_LAT + 1 + 2 * dopi_pkg::N_HORNER;

  logic            accept, comp_ok, load_we;
  logic [CW-1:0]   comp_ext;
  logic [AW-1:0]   addr;
  logic [RAMW-1:0] rdata;

  logic [31:0]     start_q, width_q;

  // operand stage 1: difference and record snapshot
  logic              v1_q, fault1_q;
  logic [3:0]        comp1_q;
  logic signed [32:0] diff1_q;
  logic signed [31:0] w1_q;

  // operand stage 2: magnitudes and quotient sign
  logic            v2_q, neg2_q;
  dopi_pkg::ctx_t  ctx2_q;
  logic [32:0]     nmag2_q;
  logic [31:0]     dmag2_q;

  logic               dv;
  dopi_pkg::ctx_t     dctx;
  logic signed [31:0] theta;

  logic               v3_q;
  dopi_pkg::hctx_t    h3_q;

  logic               hv   [dopi_pkg::N_HORNER+1];
  dopi_pkg::hctx_t    hctx [dopi_pkg::N_HORNER+1];
  logic signed [31:0] hacc [dopi_pkg::N_HORNER+1];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign comp_ok  = 32'(component_i) < 32'(COMPONENTS);
  assign load_we  = accept && (action_i == dopi_pkg::ACT_LOAD) && comp_ok;
  assign comp_ext = CW'(component_i);
  assign addr     = comp_ext[AW-1:0];

  dopi_ram #(
    .WIDTH (RAMW),
    .DEPTH (COMPONENTS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (addr),
    .wdata_i ({coef_fourth_i, coef_third_i, coef_second_i, coef_diff_i,
               coef_value_i}),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // shared step record, rewritten by every in-range load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      width_q <= '0;
    end else if (load_we) begin
      start_q <= start_time_i;
      width_q <= step_width_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept && (action_i == dopi_pkg::ACT_QUERY);
      v2_q <= v1_q;
      v3_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    comp1_q  <= component_i;
    fault1_q <= !comp_ok || (width_q == '0);
    diff1_q  <= 33'($signed(query_time_i)) - 33'($signed(start_q));
    w1_q     <= $signed(width_q);

    ctx2_q.fault <= fault1_q;
    ctx2_q.comp  <= comp1_q;
    ctx2_q.coef  <= rdata;
    nmag2_q      <= diff1_q[32] ? 33'(-diff1_q) : 33'(diff1_q);
    dmag2_q      <= w1_q[31] ? 32'(-w1_q) : 32'(w1_q);
    neg2_q       <= diff1_q[32] ^ w1_q[31];

    h3_q.ctx    <= dctx;
    h3_q.theta  <= theta;
    h3_q.theta1 <= $signed(dopi_pkg::sat_s32((66'sd1 <<< FRAC_BITS) - 66'(theta)));
  end

  // theta = (t - start) * 2^FRAC_BITS / width
  dopi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .ctx_i   (ctx2_q),
    .num_i   ({nmag2_q, {FRAC_BITS{1'b0}}}),
    .den_i   (dmag2_q),
    .neg_i   (neg2_q),
    .valid_o (dv),
    .ctx_o   (dctx),
    .quot_o  (theta)
  );

  assign hv[0]   = v3_q;
  assign hctx[0] = h3_q;
  assign hacc[0] = $signed(h3_q.ctx.coef[4]);

  // innermost first: c3 + (1-theta)*c4, then c2, c1, c0
  for (genvar g = 0; g < dopi_pkg::N_HORNER; g++) begin : g_horner
    dopi_horner #(
      .FRAC_BITS (FRAC_BITS),
      .COEF_IDX  (dopi_pkg::N_HORNER - 1 - g),
      .USE_T1    ((g % 2) == 0)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (hv[g]),
      .ctx_i   (hctx[g]),
      .acc_i   (hacc[g]),
      .valid_o (hv[g+1]),
      .ctx_o   (hctx[g+1]),
      .acc_o   (hacc[g+1])
    );
  end

  assign done_o          = hv[dopi_pkg::N_HORNER];
  assign component_out_o = hctx[dopi_pkg::N_HORNER].ctx.comp;
  assign fault_o         = hctx[dopi_pkg::N_HORNER].ctx.fault;
  assign interp_value_o  = hctx[dopi_pkg::N_HORNER].ctx.fault ? '0 :
                           hacc[dopi_pkg::N_HORNER];

  a_done_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && action_i, LAT))
    else $error("result beat without a matching query");

  a_load_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_we |=> (width_q == $past(step_width_i)) && (start_q == $past(start_time_i)))
    else $error("step record not updated by load");

  a_no_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_we |=> $stable(width_q) && $stable(start_q))
    else $error("step record changed without a load");

  a_zero_width_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && (w1_q == '0)) |-> fault1_q)
    else $error("zero step width not flagged");

endmodule

// ===== bench/dense_output_interpolator_tb.sv =====
// dense_output_interpolator_tb: self-checking bench for the dense-output interpolator.
// Drives load/query beats, predicts each query result, checks the done_o strobe.
// Depends on dopi_pkg and dense_output_interpolator.
`timescale 1ns / 1ps

module dense_output_interpolator_tb;

  localparam int NCOMP     = dopi_pkg::COMPONENTS_DEF;
  localparam int FRAC      = dopi_pkg::FRAC_BITS_DEF;
  localparam int LATENCY   = 21;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 950;

  typedef struct {
    dopi_pkg::action_e act;
    logic [3:0]  comp;
    logic [31:0] coef [5];
    logic [31:0] t0;
    logic [31:0] h;
    logic [31:0] tq;
  } beat_t;

  typedef struct {
    logic [3:0]  comp;
    logic [31:0] value;
    logic        fault;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic action_i = 1'b0;
  logic [3:0] component_i = '0;
  logic [31:0] coef_value_i = '0, coef_diff_i = '0, coef_second_i = '0;
  logic [31:0] coef_third_i = '0, coef_fourth_i = '0;
  logic [31:0] start_time_i = '0, step_width_i = '0, query_time_i = '0;
  logic done_o;
  logic [3:0] component_out_o;
  logic [31:0] interp_value_o;
  logic fault_o;

  dense_output_interpolator i_dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .component_i,
    .coef_value_i, .coef_diff_i, .coef_second_i, .coef_third_i, .coef_fourth_i,
    .start_time_i, .step_width_i, .query_time_i,
    .done_o, .component_out_o, .interp_value_o, .fault_o
  );

  always #6 clk_i = ~clk_i;

  // predictor state: mirrors the record and the coefficient RAM
  logic signed [31:0] mdl_coef [NCOMP][5];
  logic signed [31:0] mdl_t0;
  logic signed [31:0] mdl_h;

  beat_t   pending_beats [$];
  answer_t expected_answers [$];
  int      mismatches;
  int      cycle;
  bit      hold_until_drained;  // pressure: sender stops until all answers are in
  bit      stim_done;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fff_ffff;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // coef + floor(factor*acc / 2^FRAC), saturated
  function automatic logic signed [31:0] horner_step(input logic signed [31:0] c,
      input logic signed [31:0] f, input logic signed [31:0] acc);
    logic signed [65:0] prod;
    prod = 66'(f) * 66'(acc);
    return clamp32(66'(c) + (prod >>> FRAC));
  endfunction

  function automatic answer_t interpolate(input beat_t b);
    answer_t a;
    logic signed [65:0] num, quo;
    logic signed [31:0] th, th1, acc;
    a.comp = b.comp;
    a.value = '0;
    a.fault = 1'b1;
    if (mdl_h == 0) return a;
    num = (66'(signed'(b.tq)) - 66'(mdl_t0)) <<< FRAC;
    quo = num / 66'(mdl_h);  // truncates toward zero
    th  = clamp32(quo);
    th1 = clamp32((66'sd1 <<< FRAC) - 66'(th));
    acc = horner_step(mdl_coef[b.comp][3], th1, mdl_coef[b.comp][4]);
    acc = horner_step(mdl_coef[b.comp][2], th, acc);
    acc = horner_step(mdl_coef[b.comp][1], th1, acc);
    acc = horner_step(mdl_coef[b.comp][0], th, acc);
    a.value = acc;
    a.fault = 1'b0;
    return a;
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic beat_t make_load(input logic [3:0] comp, input logic [31:0] t0,
      input logic [31:0] h);
    beat_t b;
    b.act = dopi_pkg::ACT_LOAD;
    b.comp = comp;
    foreach (b.coef[k]) b.coef[k] = rnd_word();
    b.t0 = t0;
    b.h = h;
    b.tq = $urandom();
    return b;
  endfunction

  function automatic beat_t make_query(input logic [3:0] comp, input logic [31:0] tq);
    beat_t b;
    b = make_load(comp, $urandom(), $urandom());
    b.act = dopi_pkg::ACT_QUERY;
    b.tq = tq;
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch @%0d: %s got %h want %h", cycle, what, got, want);
    mismatches++;
  endtask

  // stimulus plan; every component is loaded before the random part, so no
  // random query reads a never-written entry
  initial begin : plan
    logic [31:0] t0, h;
    int n;
    beat_t b;
    // directed: queries while the width is still zero
    pending_beats.push_back(make_query(4'd0, 32'h0));
    pending_beats.push_back(make_query(4'd15, 32'h7fff_ffff));
    for (int c = 0; c < NCOMP; c++) begin
      b = make_load(4'(c), 32'h0001_0000, 32'h0000_8000);
      if (c == 15) foreach (b.coef[k]) b.coef[k] = 32'h7fff_ffff;
      if (c == 0)  foreach (b.coef[k]) b.coef[k] = 32'h8000_0000;
      pending_beats.push_back(b);
    end
    pending_beats.push_back(make_query(4'd15, 32'h0001_4000));  // mid step
    pending_beats.push_back(make_query(4'd0, 32'h0001_0000));   // theta zero
    pending_beats.push_back(make_query(4'd3, 32'h8000_0000));   // theta saturates low
    pending_beats.push_back(make_query(4'd7, 32'h7fff_ffff));   // theta saturates high
    // zero width fault, then negative width
    pending_beats.push_back(make_load(4'd5, 32'h0, 32'h0));
    pending_beats.push_back(make_query(4'd5, 32'h1234_5678));
    pending_beats.push_back(make_load(4'd5, 32'h7fff_ffff, 32'h8000_0000));
    pending_beats.push_back(make_query(4'd5, 32'h8000_0000));
    n = 0;
    while (n < N_RANDOM) begin
      if ($urandom_range(0, 3) == 0) begin
        t0 = rnd_word();
        h  = ($urandom_range(0, 19) == 0) ? 32'h0 : rnd_word();
        pending_beats.push_back(make_load(4'($urandom_range(0, NCOMP - 1)), t0, h));
      end else begin
        // mostly query near the step so theta stays in [0,1]-ish
        b = make_query(4'($urandom_range(0, NCOMP - 1)),
                       $urandom_range(0, 3) == 0 ? rnd_word()
                       : 32'(int'($urandom_range(0, 1 << 17)) - (1 << 15)));
        pending_beats.push_back(b);
      end
      n++;
    end
  end

  // driver: bursts and gaps, one pressure drain partway through
  int burst_left = 0;
  int gap_left = 0;
  int sent = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        // beat taken at this edge: apply it to the predictor
        if (action_i == dopi_pkg::ACT_LOAD) begin
          mdl_coef[component_i][0] <= coef_value_i;
          mdl_coef[component_i][1] <= coef_diff_i;
          mdl_coef[component_i][2] <= coef_second_i;
          mdl_coef[component_i][3] <= coef_third_i;
          mdl_coef[component_i][4] <= coef_fourth_i;
          mdl_t0 <= start_time_i;
          mdl_h  <= step_width_i;
        end else begin
          expected_answers.push_back(interpolate('{act: dopi_pkg::ACT_QUERY,
            comp: component_i, coef: '{default: '0}, t0: '0, h: '0,
            tq: query_time_i}));
        end
        sent++;
      end
      if (sent == 400 && !hold_until_drained) hold_until_drained = 1;
      if (hold_until_drained && expected_answers.size() == 0 && !(start && !busy))
        hold_until_drained = 0;
      if (start && busy) begin
        // beat still waiting: hold it
      end else if (pending_beats.size() == 0 || (sent == 400 && hold_until_drained) ||
                   gap_left > 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        beat_t b;
        b = pending_beats.pop_front();
        start <= 1'b1;
        action_i <= b.act;
        component_i <= b.comp;
        coef_value_i <= b.coef[0];
        coef_diff_i <= b.coef[1];
        coef_second_i <= b.coef[2];
        coef_third_i <= b.coef[3];
        coef_fourth_i <= b.coef[4];
        start_time_i <= b.t0;
        step_width_i <= b.h;
        query_time_i <= b.tq;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
        end
      end
      if (pending_beats.size() == 0 && !(start && !busy) && sent > 0 && !start)
        stim_done = 1;
    end
  end

  // monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      answer_t want;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result", {28'h0, component_out_o}, '0);
      end else begin
        want = expected_answers.pop_front();
        if (component_out_o !== want.comp)
          report_mismatch("component_out", {28'h0, component_out_o}, {28'h0, want.comp});
        if (fault_o !== want.fault)
          report_mismatch("fault", {31'h0, fault_o}, {31'h0, want.fault});
        if (interp_value_o !== want.value)
          report_mismatch("interp_value", interp_value_o, want.value);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYC) begin
      $display("[dense_output_interpolator] ERROR");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycle = 0;
    hold_until_drained = 0;
    stim_done = 0;
    mdl_t0 = '0;
    mdl_h = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_answers.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("[dense_output_interpolator] OK");
    end else begin
      $display("[dense_output_interpolator] ERROR");
    end
    $finish;
  end

endmodule
